@@ rtl/core/newton_difference_row_derivative_defines.svh @@
// Assertion macros for the row derivative block.
`ifndef NEWTON_DIFFERENCE_ROW_DERIVATIVE_DEFINES_SVH
`define NEWTON_DIFFERENCE_ROW_DERIVATIVE_DEFINES_SVH

// Same-cycle implication, off during reset.
`define NDRD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define NDRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, checked through reset as well.
`define NDRD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ndrd_pkg.sv @@
`timescale 1ns / 1ps
package ndrd_pkg;

  localparam int PIXEL_W     = 16;
  localparam int SLOPE_W     = 27;
  localparam int COLUMN_W    = 12;
  localparam int COEF_W      = 10;
  localparam int POINTS_W    = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_POINT_COUNT   = 2'd0,
    REG_BACKWARD_MODE = 2'd1
  } ndrd_reg_t;

  // Window-side control handed to the tap stage with each transfer.
  typedef struct packed {
    logic                produce;
    logic                backward;
    logic [POINTS_W-1:0] points;
    logic [COLUMN_W-1:0] column;
  } ndrd_win_ctl_t;

  // Backward-mode weight of window slot j (newest first) for p points, times 60:
  // (-1)^j * sum over k = max(1,j)..p-1 of (60/k) * C(k,j).
  // Forward mode uses the negated row mirrored across the window.
  localparam logic signed [COEF_W-1:0] S_TABLE [8][8] = '{
    '{10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0},
    '{10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0},
    '{10'sd60, -10'sd60, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0},
    '{10'sd90, -10'sd120, 10'sd30, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0},
    '{10'sd110, -10'sd180, 10'sd90, -10'sd20, 10'sd0, 10'sd0, 10'sd0, 10'sd0},
    '{10'sd125, -10'sd240, 10'sd180, -10'sd80, 10'sd15, 10'sd0, 10'sd0, 10'sd0},
    '{10'sd137, -10'sd300, 10'sd300, -10'sd200, 10'sd75, -10'sd12, 10'sd0, 10'sd0},
    '{10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0}
  };

  // Weight for window slot idx (0 = newest sample).
  function automatic logic signed [COEF_W-1:0] tap_coef(
    input logic                backward,
    input logic [POINTS_W-1:0] points,
    input logic [POINTS_W-1:0] idx
  );
    logic [POINTS_W-1:0]      j;
    logic signed [COEF_W-1:0] c;
    j = backward ? idx : POINTS_W'(points - POINTS_W'(1) - idx);
    if (idx >= points) begin
      c = '0;
    end else if (backward) begin
      c = S_TABLE[points][j];
    end else begin
      c = -S_TABLE[points][j];
    end
    return c;
  endfunction

endpackage

@@ rtl/core/ndrd_if.sv @@
`timescale 1ns / 1ps
interface ndrd_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [ndrd_pkg::PIXEL_W-1:0]  pixel;
  logic                          row_end;
  modport source (output valid, pixel, row_end, input ready);
  modport sink (input valid, pixel, row_end, output ready);
endinterface

interface ndrd_slope_if;
  logic                                valid;
  logic                                ready;
  logic signed [ndrd_pkg::SLOPE_W-1:0] slope_times_sixty;
  logic [ndrd_pkg::COLUMN_W-1:0]       column;
  modport source (output valid, slope_times_sixty, column, input ready);
  modport sink (input valid, slope_times_sixty, column, output ready);
endinterface

interface ndrd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ndrd_pkg::CFG_INDEX_W-1:0] index;
  logic [ndrd_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/newton_difference_row_derivative.sv @@
// An accepted pixel's tap products are registered in the tap stage, and their sum
//   then in the output register. Throughput: one pixel per clock while results
//   are taken; the tap products and the final sum are each one registered stage,
//   and the output register frees as soon as it is taken.
// Reset (rst, synchronous): window and row count cleared, point_count = 2,
//   backward_mode = 0, both pipeline stages empty.
`timescale 1ns / 1ps
module newton_difference_row_derivative #(
  parameter int MAX_ROW_LENGTH = 4096,
  parameter int MAX_POINTS     = 6
) (
  input  logic         clk,
  input  logic         rst,
  ndrd_cfg_if.sink     cfg,
  ndrd_pixel_if.sink   pixels,
  ndrd_slope_if.source slopes
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; unknown indexes drop.
  // ---------------------------------------------------------------------------
  logic [ndrd_pkg::POINTS_W-1:0] point_count;
  logic                          backward_mode;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count   <= ndrd_pkg::POINTS_W'(2);
      backward_mode <= 1'b0;
    end else if (cfg.valid) begin
      case (ndrd_pkg::ndrd_reg_t'(cfg.index))
        ndrd_pkg::REG_POINT_COUNT:   point_count   <= cfg.data[ndrd_pkg::POINTS_W-1:0];
        ndrd_pkg::REG_BACKWARD_MODE: backward_mode <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline:
  //   window  - sample shift line and row position; computes the new window
  //             and whether it holds a full set of points
  //   taps    - per-slot constant-weight products, registered
  //   sum     - adds the products into the output register
  // Each stage takes a transfer when it is empty or when its contents move on,
  // so a waiting result does not block the input while the tap stage is free.
  // ---------------------------------------------------------------------------
  logic                                                window_accept;
  logic [MAX_POINTS-1:0][ndrd_pkg::PIXEL_W-1:0]        window_next;
  ndrd_pkg::ndrd_win_ctl_t                             win_ctl;
  logic                                                tap_valid;
  logic                                                tap_ready;
  logic                                                sum_ready;
  logic signed [MAX_POINTS-1:0][ndrd_pkg::SLOPE_W-1:0] tap_products;
  logic [ndrd_pkg::COLUMN_W-1:0]                       tap_column;

  assign pixels.ready  = tap_ready;
  assign window_accept = pixels.valid && tap_ready;

  ndrd_window #(
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
    .MAX_POINTS     (MAX_POINTS)
  ) u_window (
    .clk           (clk),
    .rst           (rst),
    .accept        (window_accept),
    .pixel         (pixels.pixel),
    .row_end       (pixels.row_end),
    .point_count   (point_count),
    .backward_mode (backward_mode),
    .window_next   (window_next),
    .ctl           (win_ctl)
  );

  ndrd_tap_stage #(
    .MAX_POINTS (MAX_POINTS)
  ) u_taps (
    .clk         (clk),
    .rst         (rst),
    .load        (window_accept),
    .window_next (window_next),
    .ctl         (win_ctl),
    .down_ready  (sum_ready),
    .up_ready    (tap_ready),
    .valid       (tap_valid),
    .products    (tap_products),
    .column      (tap_column)
  );

  ndrd_sum_stage #(
    .MAX_POINTS (MAX_POINTS)
  ) u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tap_valid),
    .products  (tap_products),
    .in_column (tap_column),
    .in_ready  (sum_ready),
    .out_valid (slopes.valid),
    .out_ready (slopes.ready),
    .slope     (slopes.slope_times_sixty),
    .column    (slopes.column)
  );

endmodule

@@ rtl/core/ndrd_window.sv @@
`timescale 1ns / 1ps
module ndrd_window #(
  parameter int MAX_ROW_LENGTH = 4096,
  parameter int MAX_POINTS     = 6
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         accept,
  input  logic [ndrd_pkg::PIXEL_W-1:0]                 pixel,
  input  logic                                         row_end,
  input  logic [ndrd_pkg::POINTS_W-1:0]                point_count,
  input  logic                                         backward_mode,
  output logic [MAX_POINTS-1:0][ndrd_pkg::PIXEL_W-1:0] window_next,
  output ndrd_pkg::ndrd_win_ctl_t                      ctl
);

  localparam int CNT_W = $clog2(MAX_ROW_LENGTH + 1);
  localparam int CW    = (CNT_W > ndrd_pkg::COLUMN_W) ? CNT_W : ndrd_pkg::COLUMN_W;
  localparam logic [ndrd_pkg::POINTS_W-1:0] MAXP = ndrd_pkg::POINTS_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0] ROW_LIMIT = CNT_W'(MAX_ROW_LENGTH);

  logic [MAX_POINTS-1:0][ndrd_pkg::PIXEL_W-1:0] sample_window;
  logic [CNT_W-1:0]                             samples_in_row;
  logic [CNT_W-1:0]                             count_inc;
  logic [ndrd_pkg::POINTS_W-1:0]                points;
  logic                                         in_range;
  logic [CW-1:0]                                pos_ext;
  logic [CW-1:0]                                col_full;

  always_comb begin
    if (point_count < ndrd_pkg::POINTS_W'(2)) begin
      points = ndrd_pkg::POINTS_W'(2);
    end else if (point_count > MAXP) begin
      points = MAXP;
    end else begin
      points = point_count;
    end
  end

  assign in_range  = samples_in_row < ROW_LIMIT;
  assign count_inc = samples_in_row + CNT_W'(1);
  assign pos_ext   = CW'(samples_in_row);
  assign col_full  = backward_mode ? pos_ext : CW'(pos_ext + CW'(1) - CW'(points));

  always_comb begin
    window_next[0] = pixel;
    for (int i = 1; i < MAX_POINTS; i++) begin
      window_next[i] = sample_window[i-1];
    end
  end

  always_comb begin
    ctl.produce  = in_range && (count_inc >= CNT_W'(points));
    ctl.backward = backward_mode;
    ctl.points   = points;
    ctl.column   = col_full[ndrd_pkg::COLUMN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_window  <= '0;
      samples_in_row <= '0;
    end else if (accept) begin
      if (in_range) begin
        sample_window <= window_next;
      end
      if (row_end) begin
        samples_in_row <= '0;
      end else if (in_range) begin
        samples_in_row <= count_inc;
      end
    end
  end

endmodule

@@ rtl/core/ndrd_tap_stage.sv @@
`timescale 1ns / 1ps
module ndrd_tap_stage #(
  parameter int MAX_POINTS = 6
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                load,
  input  logic [MAX_POINTS-1:0][ndrd_pkg::PIXEL_W-1:0]        window_next,
  input  ndrd_pkg::ndrd_win_ctl_t                             ctl,
  input  logic                                                down_ready,
  output logic                                                up_ready,
  output logic                                                valid,
  output logic signed [MAX_POINTS-1:0][ndrd_pkg::SLOPE_W-1:0] products,
  output logic [ndrd_pkg::COLUMN_W-1:0]                       column
);

  logic signed [MAX_POINTS-1:0][ndrd_pkg::SLOPE_W-1:0] products_next;

  assign up_ready = !valid || down_ready;

  always_comb begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      logic signed [ndrd_pkg::PIXEL_W:0]   sx;
      logic signed [ndrd_pkg::COEF_W-1:0]  c;
      sx = $signed({1'b0, window_next[i]});
      c  = ndrd_pkg::tap_coef(ctl.backward, ctl.points, ndrd_pkg::POINTS_W'(i));
      products_next[i] = sx * c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= ctl.produce;
    end else if (down_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      products <= products_next;
      column   <= ctl.column;
    end
  end

endmodule

@@ rtl/core/ndrd_sum_stage.sv @@
`timescale 1ns / 1ps
module ndrd_sum_stage #(
  parameter int MAX_POINTS = 6
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                in_valid,
  input  logic signed [MAX_POINTS-1:0][ndrd_pkg::SLOPE_W-1:0] products,
  input  logic [ndrd_pkg::COLUMN_W-1:0]                       in_column,
  output logic                                                in_ready,
  output logic                                                out_valid,
  input  logic                                                out_ready,
  output logic signed [ndrd_pkg::SLOPE_W-1:0]                 slope,
  output logic [ndrd_pkg::COLUMN_W-1:0]                       column
);

  logic signed [ndrd_pkg::SLOPE_W-1:0] sum;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    sum = '0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      sum = sum + products[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      slope  <= sum;
      column <= in_column;
    end
  end

endmodule

@@ rtl/core/ndrd_checker.sv @@
`timescale 1ns / 1ps
`include "newton_difference_row_derivative_defines.svh"
module ndrd_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [ndrd_pkg::SLOPE_W-1:0] slope,
  input logic [ndrd_pkg::COLUMN_W-1:0]       column
);

  // A free output register must leave the input open.
  `NDRD_ASSERT_SAME(a_empty_out_takes_input, clk, rst, !out_valid, in_ready, "input stalled with output empty")

  // A new result can only arrive from a stage that was free to move.
  `NDRD_ASSERT_SAME(a_result_from_flow, clk, rst, $rose(out_valid), $past(in_ready), "result appeared while pipeline was stalled")

  // Reset empties the output.
  `NDRD_ASSERT_NEXT_ALWAYS(a_reset_clears_out, clk, rst, !out_valid, "output valid right after reset")

  // A stalled result holds.
  `NDRD_ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(slope) && $stable(column), "stalled result changed")

endmodule

bind newton_difference_row_derivative ndrd_checker u_ndrd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pixels.ready),
  .out_valid (slopes.valid),
  .out_ready (slopes.ready),
  .slope     (slopes.slope_times_sixty),
  .column    (slopes.column)
);

@@ tb/ndrd_slope_checker.sv @@
`timescale 1ns / 1ps
module ndrd_slope_checker #(
  parameter int MAX_ROW_LENGTH = 4096,
  parameter int MAX_POINTS     = 6
) (
  input  logic  clk,
  input  logic  rst,
  ndrd_cfg_if   cfg,
  ndrd_pixel_if pixels,
  ndrd_slope_if slopes,
  output int    error_count,
  output int    outstanding,
  output int    slopes_checked
);

  typedef struct packed {
    logic signed [ndrd_pkg::SLOPE_W-1:0] slope;
    logic [ndrd_pkg::COLUMN_W-1:0]       column;
  } slope_est_t;

  slope_est_t                    slopes_due[$];
  slope_est_t                    oldest;
  logic [ndrd_pkg::PIXEL_W-1:0]  history [MAX_POINTS];  // newest sample in slot 0
  int unsigned                   row_pos;
  logic [ndrd_pkg::POINTS_W-1:0] points_reg;
  logic                          backward_reg;
  int                            mismatches = 0;
  int                            checked = 0;

  // Derivative times 60 from a difference table built oldest-first.
  function automatic longint newton_slope60(int p, bit backward);
    longint diffs [MAX_POINTS];
    longint acc;
    acc = 0;
    for (int m = 0; m < p; m++) diffs[m] = longint'(history[p-1-m]);
    for (int k = 1; k < p; k++) begin
      for (int m = 0; m + k < p; m++) diffs[m] = diffs[m+1] - diffs[m];
      if (backward) acc += longint'(60 / k) * diffs[p-1-k];
      else if (k % 2 == 1) acc += longint'(60 / k) * diffs[0];
      else acc -= longint'(60 / k) * diffs[0];
    end
    return acc;
  endfunction

  task automatic take_pixel(input logic [ndrd_pkg::PIXEL_W-1:0] px, input logic last);
    int         p;
    slope_est_t est;
    if (row_pos < MAX_ROW_LENGTH) begin
      p = (points_reg < 2) ? 2 : (points_reg > MAX_POINTS) ? MAX_POINTS : int'(points_reg);
      for (int i = MAX_POINTS - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = px;
      row_pos++;
      if (row_pos >= p) begin
        est.slope  = ndrd_pkg::SLOPE_W'(newton_slope60(p, backward_reg));
        est.column = ndrd_pkg::COLUMN_W'(backward_reg ? row_pos - 1 : row_pos - p);
        slopes_due.push_back(est);
      end
    end
    if (last) row_pos = 0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      slopes_due.delete();
      foreach (history[i]) history[i] = '0;
      row_pos      = 0;
      points_reg   = 3'd2;
      backward_reg = 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          ndrd_pkg::REG_POINT_COUNT:   points_reg = cfg.data;
          ndrd_pkg::REG_BACKWARD_MODE: backward_reg = cfg.data[0];
          default: ;
        endcase
      end
      if (slopes.valid && slopes.ready) begin
        checked++;
        if (slopes_due.size() == 0) begin
          $error("unexpected slope transfer: slope_times_sixty %0d column %0d",
                 slopes.slope_times_sixty, slopes.column);
          mismatches++;
        end else begin
          oldest = slopes_due.pop_front();
          if (slopes.slope_times_sixty !== oldest.slope) begin
            $error("slope_times_sixty: expected %0d, got %0d",
                   oldest.slope, slopes.slope_times_sixty);
            mismatches++;
          end
          if (slopes.column !== oldest.column) begin
            $error("column: expected %0d, got %0d", oldest.column, slopes.column);
            mismatches++;
          end
        end
      end
      if (pixels.valid && pixels.ready) take_pixel(pixels.pixel, pixels.row_end);
    end
    error_count    <= mismatches;
    outstanding    <= slopes_due.size();
    slopes_checked <= checked;
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;

  // Drain wait, long enough for a result to pass the tap and sum registers.
  localparam int LATENCY_WAIT  = 6;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_PIXELS = 1950;

  logic clk;
  logic rst;

  ndrd_cfg_if   cfg_ch ();
  ndrd_pixel_if pix_ch ();
  ndrd_slope_if slope_ch ();

  int error_count;
  int outstanding;
  int slopes_checked;
  int cycle_count = 0;
  int pixels_sent = 0;
  int cfg_writes = 0;
  bit calm = 1'b0;  // phase with no idling on either side

  newton_difference_row_derivative u_top (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .pixels (pix_ch),
    .slopes (slope_ch)
  );

  ndrd_slope_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg_ch),
    .pixels         (pix_ch),
    .slopes         (slope_ch),
    .error_count    (error_count),
    .outstanding    (outstanding),
    .slopes_checked (slopes_checked)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Hard stop in case a result never shows up.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Idle length: mostly short, now and then long.
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 75) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int source_gap();
    if (calm || $urandom_range(0, 99) < 65) return 0;
    return idle_len();
  endfunction

  // Result side: random stalls of varied length, none in calm phases.
  initial begin : result_sink
    int hold;
    slope_ch.ready <= 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        slope_ch.ready <= 1'b0;
        hold--;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
        slope_ch.ready <= 1'b0;
        hold = idle_len() - 1;
      end else begin
        slope_ch.ready <= 1'b1;
      end
    end
  end

  // One pixel transfer. valid stays high between back-to-back pixels.
  task automatic send_pixel(input logic [ndrd_pkg::PIXEL_W-1:0] px, input logic last);
    int gap;
    gap = source_gap();
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid   <= 1'b1;
    pix_ch.pixel   <= px;
    pix_ch.row_end <= last;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    pixels_sent++;
  endtask

  // Whole row from a list; the last pixel closes it.
  task automatic send_seq(input logic [ndrd_pkg::PIXEL_W-1:0] vals[$]);
    foreach (vals[i]) send_pixel(vals[i], i == vals.size() - 1);
  endtask

  // Drop valid, let the pipe drain, then wait LATENCY_WAIT again for pixels
  // that produce no result but may still be in flight.
  task automatic settle();
    pix_ch.valid <= 1'b0;
    repeat (LATENCY_WAIT) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  // Register write; only called with the block drained.
  task automatic write_reg(input ndrd_pkg::ndrd_reg_t which,
                           input logic [ndrd_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= which;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    cfg_writes++;
    @(posedge clk);
  endtask

  function automatic logic [ndrd_pkg::PIXEL_W-1:0] make_pixel(
    int style, logic [ndrd_pkg::PIXEL_W-1:0] prev
  );
    case (style)
      0:       return ndrd_pkg::PIXEL_W'($urandom);
      1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      2:       return prev + ndrd_pkg::PIXEL_W'($urandom_range(0, 14)) - 16'd7;  // smooth ramp
      default: return ndrd_pkg::PIXEL_W'($urandom & $urandom);                 // sparse bits
    endcase
  endfunction

  task automatic send_row(input int len, input bit close);
    int                           style;
    logic [ndrd_pkg::PIXEL_W-1:0] px;
    style = $urandom_range(0, 3);
    px = ndrd_pkg::PIXEL_W'($urandom);
    for (int i = 0; i < len; i++) begin
      px = make_pixel(style, px);
      send_pixel(px, close && (i == len - 1));
    end
  endtask

  function automatic int row_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 12);
    if (r < 95) return $urandom_range(13, 60);
    return $urandom_range(61, 300);
  endfunction

  initial begin : stimulus
    int random_start;
    int rows;
    int r;

    rst            <= 1'b1;
    pix_ch.valid   <= 1'b0;
    pix_ch.pixel   <= '0;
    pix_ch.row_end <= 1'b0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= ndrd_pkg::REG_POINT_COUNT;
    cfg_ch.data    <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings (two points, forward): full-swing row, then a
    // one-pixel row that is too short for any estimate.
    send_seq('{16'd0, 16'hFFFF, 16'd0, 16'hFFFF});
    send_seq('{16'd1234});
    settle();

    // Six points, backward. Data 3 checks that only bit 0 sets the mode.
    write_reg(ndrd_pkg::REG_POINT_COUNT, 3'd6);
    write_reg(ndrd_pkg::REG_BACKWARD_MODE, 3'd3);
    send_seq('{16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0});
    settle();

    // Six points forward (data 2 has bit 0 clear).
    write_reg(ndrd_pkg::REG_BACKWARD_MODE, 3'd2);
    send_seq('{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF});
    settle();

    // Point count below range acts as two.
    write_reg(ndrd_pkg::REG_POINT_COUNT, 3'd0);
    send_seq('{16'd100, 16'd50});
    settle();

    // Point count above range acts as six, backward.
    write_reg(ndrd_pkg::REG_POINT_COUNT, 3'd7);
    write_reg(ndrd_pkg::REG_BACKWARD_MODE, 3'd1);
    send_seq('{16'd1, 16'd2, 16'd4, 16'd8, 16'd16, 16'd32});
    settle();

    // Random phases: new settings while drained, a few rows each; the last
    // row is sometimes left open so settings change mid-row.
    random_start = pixels_sent;
    while (pixels_sent < random_start + RANDOM_PIXELS) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          write_reg(ndrd_pkg::REG_POINT_COUNT,
                    3'($urandom_range(0, 1) ? 7 : $urandom_range(0, 1)));
        end else begin
          write_reg(ndrd_pkg::REG_POINT_COUNT, 3'($urandom_range(2, 6)));
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        write_reg(ndrd_pkg::REG_BACKWARD_MODE, 3'($urandom_range(0, 7)));
      end
      rows = $urandom_range(1, 6);
      for (int i = 0; i < rows; i++)
        send_row(row_len(), (i < rows - 1) || ($urandom_range(0, 2) != 0));
      settle();
    end
    calm = 1'b0;

    $display("tb: %0d pixels, %0d slope results checked, %0d register writes",
             pixels_sent, slopes_checked, cfg_writes);
    $display("tb: point counts 0..7 in both modes, rows of 1 to 300 pixels, open rows");
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
